>>> hdl/lalloc_pkg.sv
// ----------------------------------------------------------------------------
// lalloc_pkg
// Shared types and constants for the line allocator with preemption.
// ----------------------------------------------------------------------------
package lalloc_pkg;

  localparam int LINE_COUNT = 16;
  localparam int IDX_W      = $clog2(LINE_COUNT);
  localparam int CNT_W      = $clog2(LINE_COUNT + 1);

  localparam int CMD_W      = 2;
  localparam int OWNER_W    = 8;
  localparam int PRIO_W     = 8;
  localparam int LINE_W     = 4;
  localparam int ACTIVE_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_CONNECT  = 2'd1,
    CMD_RELEASE  = 2'd2,
    CMD_SET_LINE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATE_MODE  = 1'd0,
    CFG_ACTIVE_LINES = 1'd1
  } cfg_reg_t;

  localparam logic signed [OWNER_W-1:0] OWNER_NONE = -8'sd1;

endpackage

>>> hdl/lalloc_req_if.sv
// ----------------------------------------------------------------------------
// lalloc_req_if
// Request channel of the line allocator: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface lalloc_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [7:0] requester_owner;
  logic [7:0]        request_priority;
  logic [3:0]        target_line;
  logic signed [7:0] new_owner;
  logic              new_incoming_block;

  modport source (
    output valid, command, requester_owner, request_priority, target_line,
           new_owner, new_incoming_block,
    input  ready
  );

  modport sink (
    input  valid, command, requester_owner, request_priority, target_line,
           new_owner, new_incoming_block,
    output ready
  );
endinterface

>>> hdl/lalloc_rsp_if.sv
// ----------------------------------------------------------------------------
// lalloc_rsp_if
// Response channel of the line allocator: valid/ready plus grant fields.
// ----------------------------------------------------------------------------
interface lalloc_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic [3:0] granted_line;
  logic       was_preempted;

  modport source (
    output valid, granted, granted_line, was_preempted,
    input  ready
  );

  modport sink (
    input  valid, granted, granted_line, was_preempted,
    output ready
  );
endinterface

>>> hdl/line_allocator_with_preemption_top.sv
// ----------------------------------------------------------------------------
// line_allocator_with_preemption_top
// Line table with ring-pointer allocation, owner reservation and priority
// preemption; one shared compare unit scans one line per cycle.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_req   | in  | valid/ready        | command, owner, priority, line, attrs
//  out_rsp  | out | valid/ready        | granted, granted_line, was_preempted
//  cfg_*    | in  | cfg_wr_en strobe   | cfg_index, cfg_wdata
//
//  Table commands respond in the cycle after acceptance; allocate scans
//  min(active_lines, LINE_COUNT) lines, one per cycle via the shared
//  comparator, then decides (with no active lines it responds like a table
//  command). in_req.ready is high only in idle, which follows each response
//  handshake. A stalled response holds the block until out_rsp.ready. rst_n
//  is synchronous; after it the table is free, unowned and at priority zero.
// ----------------------------------------------------------------------------
module line_allocator_with_preemption_top
  import lalloc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lalloc_req_if.sink            in_req,
  lalloc_rsp_if.source          out_rsp,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_RESP   = 4'b1000
  } state_t;

  state_t state_r;

  // Configuration
  logic                rotate_mode_r;
  logic [ACTIVE_W-1:0] active_lines_r;

  // Line table
  logic                      busy_r   [LINE_COUNT];
  logic                      seized_r [LINE_COUNT];
  logic                      block_r  [LINE_COUNT];
  logic signed [OWNER_W-1:0] owner_r  [LINE_COUNT];
  logic [PRIO_W-1:0]         prio_r   [LINE_COUNT];
  logic [IDX_W-1:0]          sp_r;

  // Request capture and scan state
  logic signed [OWNER_W-1:0] req_owner_r;
  logic [PRIO_W-1:0]         req_prio_r;
  logic [CNT_W-1:0]          n_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      own_hit_r;
  logic [IDX_W-1:0]          own_idx_r;
  logic                      free_hit_r;
  logic [IDX_W-1:0]          free_idx_r;
  logic                      best_hit_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic [PRIO_W-1:0]         best_prio_r;

  // Response registers
  logic              rsp_granted_r;
  logic [LINE_W-1:0] rsp_line_r;
  logic              rsp_pre_r;

  logic              in_fire;
  logic              out_fire;
  cmd_t              in_cmd;
  logic [CNT_W-1:0]  n_eff;
  logic              tgt_ok;
  logic [IDX_W-1:0]  tgt_idx;
  logic              cur_avail;
  logic              cur_busy;
  logic              owner_match;
  logic              prio_lower;
  logic              scan_last;
  logic              idx_wrap;

  assign in_req.ready      = (state_r == ST_IDLE);
  assign out_rsp.valid     = (state_r == ST_RESP);
  assign out_rsp.granted       = rsp_granted_r;
  assign out_rsp.granted_line  = rsp_line_r;
  assign out_rsp.was_preempted = rsp_pre_r;

  assign in_fire  = in_req.valid & in_req.ready;
  assign out_fire = out_rsp.valid & out_rsp.ready;
  assign in_cmd   = cmd_t'(in_req.command);

  always_comb begin
    if (int'(active_lines_r) > LINE_COUNT) begin
      n_eff = CNT_W'(LINE_COUNT);
    end else begin
      n_eff = CNT_W'(active_lines_r);
    end
  end

  assign tgt_ok  = int'(in_req.target_line) < LINE_COUNT;
  assign tgt_idx = IDX_W'(in_req.target_line);

  // Shared scan datapath: one table entry read at idx_r per cycle
  assign cur_busy    = busy_r[idx_r];
  assign cur_avail   = !busy_r[idx_r] && !seized_r[idx_r] && !block_r[idx_r];
  assign owner_match = !req_owner_r[OWNER_W-1] && (owner_r[idx_r] == req_owner_r);
  assign prio_lower  = !best_hit_r || (best_prio_r > prio_r[idx_r]);
  assign scan_last   = (cnt_r + CNT_W'(1)) == n_r;
  assign idx_wrap    = (CNT_W'(idx_r) + CNT_W'(1)) == n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rotate_mode_r  <= 1'b0;
      active_lines_r <= ACTIVE_W'(16);
      sp_r           <= '0;
      for (int i = 0; i < LINE_COUNT; i++) begin
        busy_r[i]   <= 1'b0;
        seized_r[i] <= 1'b0;
        block_r[i]  <= 1'b0;
        owner_r[i]  <= OWNER_NONE;
        prio_r[i]   <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ROTATE_MODE:  rotate_mode_r  <= cfg_wdata[0];
          CFG_ACTIVE_LINES: active_lines_r <= cfg_wdata[ACTIVE_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            rsp_granted_r <= 1'b0;
            rsp_line_r    <= '0;
            rsp_pre_r     <= 1'b0;
            req_owner_r   <= in_req.requester_owner;
            req_prio_r    <= in_req.request_priority;
            n_r           <= n_eff;
            cnt_r         <= '0;
            own_hit_r     <= 1'b0;
            free_hit_r    <= 1'b0;
            best_hit_r    <= 1'b0;
            state_r       <= ((in_cmd == CMD_ALLOC) && (n_eff != '0)) ? ST_SCAN : ST_RESP;
            case (in_cmd)
              CMD_ALLOC: begin
                if (n_eff != '0) begin
                  // restart the ring at line 0 when the pointer is out of range
                  if (CNT_W'(sp_r) >= n_eff) begin
                    sp_r  <= '0;
                    idx_r <= '0;
                  end else begin
                    idx_r <= sp_r;
                  end
                end
              end
              CMD_CONNECT: begin
                if (tgt_ok) begin
                  busy_r[tgt_idx]   <= 1'b1;
                  seized_r[tgt_idx] <= 1'b0;
                  prio_r[tgt_idx]   <= in_req.request_priority;
                end
              end
              CMD_RELEASE: begin
                if (tgt_ok) begin
                  busy_r[tgt_idx]   <= 1'b0;
                  seized_r[tgt_idx] <= 1'b0;
                  prio_r[tgt_idx]   <= '0;
                end
              end
              CMD_SET_LINE: begin
                if (tgt_ok) begin
                  owner_r[tgt_idx] <= in_req.new_owner;
                  block_r[tgt_idx] <= in_req.new_incoming_block;
                end
              end
              default: ;
            endcase
          end
        end

        ST_SCAN: begin
          // track first reserved hit, first free hit and first lowest busy line
          if (!own_hit_r && cur_avail && owner_match) begin
            own_hit_r <= 1'b1;
            own_idx_r <= idx_r;
          end
          if (!free_hit_r && cur_avail) begin
            free_hit_r <= 1'b1;
            free_idx_r <= idx_r;
          end
          if (cur_busy && prio_lower) begin
            best_hit_r  <= 1'b1;
            best_idx_r  <= idx_r;
            best_prio_r <= prio_r[idx_r];
          end
          if (scan_last) begin
            state_r <= ST_DECIDE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
            idx_r <= idx_wrap ? '0 : idx_r + IDX_W'(1);
          end
        end

        ST_DECIDE: begin
          state_r <= ST_RESP;
          if (own_hit_r) begin
            seized_r[own_idx_r] <= 1'b1;
            rsp_granted_r       <= 1'b1;
            rsp_line_r          <= LINE_W'(own_idx_r);
            if (rotate_mode_r) begin
              sp_r <= own_idx_r;
            end
          end else if (free_hit_r) begin
            seized_r[free_idx_r] <= 1'b1;
            rsp_granted_r        <= 1'b1;
            rsp_line_r           <= LINE_W'(free_idx_r);
            if (rotate_mode_r) begin
              sp_r <= free_idx_r;
            end
          end else if (best_hit_r && (best_prio_r < req_prio_r)) begin
            busy_r[best_idx_r]   <= 1'b0;
            seized_r[best_idx_r] <= 1'b1;
            prio_r[best_idx_r]   <= '0;
            rsp_granted_r        <= 1'b1;
            rsp_line_r           <= LINE_W'(best_idx_r);
            rsp_pre_r            <= 1'b1;
          end
        end

        ST_RESP: begin
          if (out_fire) begin
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_excl_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !out_rsp.valid)
    else $error("request accepted while a response is pending");

  a_pre_implies_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (!out_rsp.was_preempted || out_rsp.granted))
    else $error("preemption flagged without a grant");

  a_no_grant_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && !out_rsp.granted) |-> (out_rsp.granted_line == '0))
    else $error("nonzero line reported without a grant");

  a_table_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cmd != CMD_ALLOC)) |=> (out_rsp.valid && !out_rsp.granted))
    else $error("table command did not respond next cycle");
`endif

endmodule
